// ===== rtl/core/frp_pkg.sv =====
`timescale 1ns / 1ps

package frp_pkg;

  localparam int NUM_FORMATS = 8;
  localparam int NUM_DRIVES  = 4;
  localparam int TABLE_LEN   = 8;
  localparam int BLOCK_W     = 12;
  localparam int SECT_W      = 5;
  localparam int CNT_W       = $clog2(BLOCK_W);
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LIMIT = 1'd1;

  localparam logic [4:0] RETRY_LIMIT_RST = 5'd12;
  localparam logic [3:0] TRACK_LIMIT_RST = 4'd4;
  localparam logic [7:0] HEAD_UNKNOWN    = 8'hFF;

  localparam logic [7:0] SEEK_ST0_MASK = 8'hF8;
  localparam logic [7:0] SEEK_ST0_OK   = 8'h20;
  localparam logic [7:0] XFER_ST0_MASK = 8'hF8;
  localparam logic [7:0] XFER_ST1_MASK = 8'hBF;
  localparam logic [7:0] XFER_ST2_MASK = 8'h73;
  localparam logic [2:0] SEEK_REPLIES  = 3'd2;
  localparam logic [2:0] XFER_REPLIES  = 3'd7;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_SEEK    = 2'd1,
    KIND_XFER    = 2'd2,
    KIND_CHANGE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_START    = 3'd0,
    OUT_CACHED   = 3'd1,
    OUT_DONE     = 3'd2,
    OUT_RETRY    = 3'd3,
    OUT_FAIL     = 3'd4,
    OUT_PROTECT  = 3'd5,
    OUT_IGNORED  = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_XFER = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIV    = 2'd1,
    ST_COMMIT = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    kind_t        kind;
    logic [1:0]   drive;
    logic [2:0]   format_type;
    logic [11:0]  block;
    logic         is_write;
    logic [2:0]   reply_count;
    logic [7:0]   status0;
    logic [7:0]   status1;
    logic [7:0]   status2;
  } in_item_t;

  typedef struct packed {
    outcome_t     outcome;
    logic [6:0]   cylinder;
    logic         head_number;
    logic [4:0]   sector_number;
    logic [7:0]   seek_cylinder;
    logic         need_seek;
    logic         whole_track;
    logic [5:0]   cache_slot;
    logic         cache_write;
    logic         want_reset;
    logic         want_recalibrate;
    logic [4:0]   retries;
  } out_item_t;

  typedef struct packed {
    logic         load;
    logic         div_step;
    logic         commit;
  } frp_cmd_t;

  typedef struct packed {
    logic         in_request;
    logic         div_last;
  } frp_status_t;

  typedef struct packed {
    logic [11:0]  size;
    logic [4:0]   sect;
    logic         stretch;
  } fmt_t;

  localparam fmt_t FMT_TABLE [TABLE_LEN] = '{
    '{size: 12'd0,    sect: 5'd0,  stretch: 1'b0},
    '{size: 12'd720,  sect: 5'd9,  stretch: 1'b0},
    '{size: 12'd2400, sect: 5'd15, stretch: 1'b0},
    '{size: 12'd720,  sect: 5'd9,  stretch: 1'b1},
    '{size: 12'd1440, sect: 5'd9,  stretch: 1'b0},
    '{size: 12'd720,  sect: 5'd9,  stretch: 1'b1},
    '{size: 12'd1440, sect: 5'd9,  stretch: 1'b0},
    '{size: 12'd2880, sect: 5'd18, stretch: 1'b0}
  };

  // Formats outside the supported range read as the empty format.
  function automatic fmt_t fmt_lookup(input logic [2:0] ft);
    fmt_t f;
    f = FMT_TABLE[0];
    if (int'(ft) < NUM_FORMATS) begin
      f = FMT_TABLE[ft];
    end
    return f;
  endfunction

endpackage

// ===== rtl/core/frp_ctrl.sv =====
`timescale 1ns / 1ps

module frp_ctrl import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  frp_status_t status,
  output frp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_request ? ST_DIV : ST_COMMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.commit ? 1'b1 : (out_valid && out_stall);
  end

endmodule

// ===== rtl/core/frp_datapath.sv =====
`timescale 1ns / 1ps

module frp_datapath import frp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  frp_cmd_t              cmd,
  output frp_status_t           status,
  output out_item_t             out_item
);

  typedef struct packed {
    logic        valid;
    logic [1:0]  drive;
    logic        write;
    logic [6:0]  cyl;
    logic        head;
    logic [4:0]  sect;
    logic [7:0]  seek;
    logic [5:0]  slot;
    phase_t      phase;
    logic        whole;
  } pend_t;

  // Configuration
  logic [4:0]  retry_limit;
  logic [3:0]  track_read_limit;

  // Latched event and divider
  in_item_t         item;
  logic [BLOCK_W-1:0] dvd;
  logic [SECT_W-1:0]  rem;
  logic [CNT_W-1:0]   cnt;

  // Architectural state
  logic [1:0]  active_drive;
  logic [7:0]  head_position;
  logic [7:0]  cache_cylinder;
  logic [1:0]  cache_drive;
  logic        cache_valid;
  logic [4:0]  error_tally;
  logic        reset_flag;
  logic        recal_flag;
  pend_t       pend;

  logic [1:0]  active_drive_next;
  logic [7:0]  head_position_next;
  logic [7:0]  cache_cylinder_next;
  logic [1:0]  cache_drive_next;
  logic        cache_valid_next;
  logic [4:0]  error_tally_next;
  logic        reset_flag_next;
  logic        recal_flag_next;
  pend_t       pend_next;
  out_item_t   res;

  fmt_t        fmt_cur;
  logic [SECT_W:0] trial;
  logic        trial_fits;

  assign fmt_cur = fmt_lookup(item.format_type);

  assign status.in_request = (in_item.kind == KIND_REQUEST);
  assign status.div_last   = (cnt == CNT_W'(BLOCK_W - 1));

  // One restoring division step per cycle: block / sectors per track.
  assign trial      = {rem, dvd[BLOCK_W-1]};
  assign trial_fits = (trial >= {1'b0, fmt_cur.sect});

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit      <= RETRY_LIMIT_RST;
      track_read_limit <= TRACK_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT: retry_limit      <= cfg_data[4:0];
        CFG_TRACK_LIMIT: track_read_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      dvd  <= in_item.block;
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[BLOCK_W-2:0], trial_fits};
      rem <= trial_fits ? SECT_W'(trial - {1'b0, fmt_cur.sect}) : trial[SECT_W-1:0];
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_drive   <= '0;
      head_position  <= HEAD_UNKNOWN;
      cache_cylinder <= '0;
      cache_drive    <= '0;
      cache_valid    <= 1'b0;
      error_tally    <= '0;
      reset_flag     <= 1'b0;
      recal_flag     <= 1'b0;
      pend           <= '0;
    end else if (cmd.commit) begin
      active_drive   <= active_drive_next;
      head_position  <= head_position_next;
      cache_cylinder <= cache_cylinder_next;
      cache_drive    <= cache_drive_next;
      cache_valid    <= cache_valid_next;
      error_tally    <= error_tally_next;
      reset_flag     <= reset_flag_next;
      recal_flag     <= recal_flag_next;
      pend           <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item <= res;
    end
  end

  always_comb begin
    logic        attempt;
    logic        retry;
    logic        err;
    logic        geo;
    logic        hit;
    logic        flags;
    logic        need;
    logic        whole;
    logic [5:0]  tally_inc;
    logic [10:0] cyl_full;
    logic        range_bad;

    active_drive_next   = active_drive;
    head_position_next  = head_position;
    cache_cylinder_next = cache_cylinder;
    cache_drive_next    = cache_drive;
    cache_valid_next    = cache_valid;
    error_tally_next    = error_tally;
    reset_flag_next     = reset_flag;
    recal_flag_next     = recal_flag;
    pend_next           = pend;
    res                 = '0;
    res.outcome         = OUT_IGNORED;
    attempt             = 1'b0;
    retry               = 1'b0;
    err                 = 1'b0;
    geo                 = 1'b0;
    hit                 = 1'b0;
    flags               = 1'b0;
    need                = 1'b0;
    whole               = 1'b0;
    tally_inc           = {1'b0, error_tally} + 6'd1;
    cyl_full            = dvd[BLOCK_W-1:1];
    range_bad           = ({1'b0, item.block} + 13'd2) > {1'b0, fmt_cur.size}
                          || fmt_cur.sect == '0;

    unique case (item.kind)
      KIND_REQUEST: begin
        pend_next.valid  = 1'b0;
        pend_next.phase  = PH_IDLE;
        error_tally_next = '0;
        res.outcome      = OUT_FAIL;
        if (int'(item.drive) < NUM_DRIVES) begin
          if (item.drive != active_drive) begin
            head_position_next = HEAD_UNKNOWN;
          end
          active_drive_next = item.drive;
          if (!range_bad) begin
            pend_next.valid = 1'b1;
            pend_next.drive = item.drive;
            pend_next.write = item.is_write;
            pend_next.cyl   = cyl_full[6:0];
            pend_next.head  = dvd[0];
            pend_next.sect  = rem + 5'd1;
            pend_next.seek  = fmt_cur.stretch ? {cyl_full[6:0], 1'b0} : cyl_full[7:0];
            pend_next.slot  = 6'(rem) + (dvd[0] ? 6'(fmt_cur.sect) : 6'd0);
            attempt         = 1'b1;
          end
        end
      end
      KIND_SEEK: begin
        if (pend.valid && pend.phase == PH_SEEK) begin
          if (item.reply_count != SEEK_REPLIES
              || (item.status0 & SEEK_ST0_MASK) != SEEK_ST0_OK
              || item.status1 != pend.seek) begin
            recal_flag_next = 1'b1;
            err             = 1'b1;
          end else begin
            head_position_next = item.status1;
            pend_next.phase    = PH_XFER;
            if (pend.whole) begin
              cache_valid_next = 1'b0;
            end
            res.outcome     = OUT_START;
            res.whole_track = pend.whole;
            geo             = 1'b1;
          end
        end
      end
      KIND_XFER: begin
        if (pend.valid && pend.phase == PH_XFER) begin
          if (item.reply_count != XFER_REPLIES
              || (item.status0 & XFER_ST0_MASK) != '0
              || (item.status1 & XFER_ST1_MASK) != '0
              || (item.status2 & XFER_ST2_MASK) != '0) begin
            if (item.status1[1]) begin
              pend_next.valid = 1'b0;
              pend_next.phase = PH_IDLE;
              res.outcome     = OUT_PROTECT;
              geo             = 1'b1;
            end else begin
              err = 1'b1;
            end
          end else begin
            if (pend.whole) begin
              cache_cylinder_next = pend.seek;
              cache_drive_next    = pend.drive;
              cache_valid_next    = 1'b1;
              res.cache_slot      = pend.slot;
            end
            pend_next.valid = 1'b0;
            pend_next.phase = PH_IDLE;
            res.outcome     = OUT_DONE;
            res.whole_track = pend.whole;
            geo             = 1'b1;
          end
        end
      end
      KIND_CHANGE: begin
        if (int'(item.drive) < NUM_DRIVES) begin
          cache_valid_next = 1'b0;
        end
      end
      default: ;
    endcase

    // Error escalation: recalibrate first, reset past half the limit.
    if (err) begin
      head_position_next = HEAD_UNKNOWN;
      error_tally_next   = tally_inc[5] ? 5'd31 : tally_inc[4:0];
      if (tally_inc > {2'b00, retry_limit[4:1]}) begin
        reset_flag_next = 1'b1;
      end else begin
        recal_flag_next = 1'b1;
      end
      if (tally_inc > {1'b0, retry_limit}) begin
        pend_next.valid = 1'b0;
        pend_next.phase = PH_IDLE;
        res.outcome     = OUT_FAIL;
        geo             = 1'b1;
      end else begin
        attempt = 1'b1;
        retry   = 1'b1;
      end
    end

    res.want_reset       = reset_flag_next;
    res.want_recalibrate = recal_flag_next;
    res.retries          = error_tally_next;

    if (attempt) begin
      geo = 1'b1;
      hit = cache_valid && cache_cylinder == pend_next.seek
            && cache_drive == pend_next.drive;
      if (hit && !pend_next.write) begin
        pend_next.valid = 1'b0;
        pend_next.phase = PH_IDLE;
        res.outcome     = OUT_CACHED;
        res.cache_slot  = pend_next.slot;
      end else begin
        whole = !pend_next.write && (error_tally_next < {1'b0, track_read_limit});
        flags = reset_flag_next || recal_flag_next;
        need  = flags || pend_next.seek != head_position_next;
        res.outcome     = retry ? OUT_RETRY : OUT_START;
        res.need_seek   = need;
        res.whole_track = whole;
        res.cache_slot  = hit ? pend_next.slot : 6'd0;
        res.cache_write = hit;
        // The reset and recalibrate exchanges are taken as done once reported.
        if (flags) begin
          reset_flag_next    = 1'b0;
          recal_flag_next    = 1'b0;
          head_position_next = HEAD_UNKNOWN;
        end
        pend_next.whole = whole;
        pend_next.phase = need ? PH_SEEK : PH_XFER;
        if (!need && whole) begin
          cache_valid_next = 1'b0;
        end
      end
    end

    if (geo) begin
      res.cylinder      = pend_next.cyl;
      res.head_number   = pend_next.head;
      res.sector_number = pend_next.sect;
      res.seek_cylinder = pend_next.seek;
    end
  end

endmodule

// ===== rtl/core/floppy_request_planner.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_item (in_item_t)
// out       output     out_valid / out_stall out_item (out_item_t)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A request event is latched, then divided bit-serially by sectors per track,
// then committed; no new event is taken until the commit. Seek, transfer-result
// and disk-change events skip the divide and go straight to the commit.
// The result register lets the next event be taken while a result is held.
// Reset (rst, synchronous) loads the default register values and empties state.
// A stalled output holds its result and delays the commit of the next one.

module floppy_request_planner import frp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  frp_cmd_t    cmd;
  frp_status_t status;

  frp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  frp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/frp_checker.sv =====
`timescale 1ns / 1ps

module frp_checker import frp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the event was processed");

  a_seek_only_on_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.need_seek |->
      out_item.outcome == OUT_START || out_item.outcome == OUT_RETRY)
    else $error("seek requested on an outcome that starts nothing");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.outcome == OUT_IGNORED |->
      out_item.seek_cylinder == '0 && out_item.cache_slot == '0 && !out_item.whole_track)
    else $error("ignored event carries geometry");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind floppy_request_planner frp_checker u_frp_checker (.*);

// ===== tb/floppy_request_planner_tb.sv =====
`timescale 1ns / 1ps

module floppy_request_planner_tb;
  import frp_pkg::*;

  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRESSURE_AT   = 600;
  localparam int PRESSURE_LEN  = 400;
  localparam int PRINT_CAP     = 100;
  localparam logic [7:0] ST1_NOT_WRITABLE = 8'h02;

  typedef struct packed {
    logic [11:0] size;
    logic [4:0]  spt;
    logic        stretch;
  } disk_geom_t;

  class planner_model;
    logic [4:0] err_limit;
    logic [3:0] whole_limit;
    logic [1:0] sel_drive;
    logic [7:0] head_at;
    logic [7:0] cached_cyl;
    logic [1:0] cached_drive;
    bit         cached_ok;
    logic [4:0] err_cnt;
    bit         want_rst;
    bit         want_recal;
    bit         job_live;
    logic [1:0] job_drive;
    bit         job_wr;
    logic [6:0] job_cyl;
    bit         job_head;
    logic [4:0] job_sect;
    logic [7:0] job_seek;
    logic [5:0] job_slot;
    phase_t     job_phase;
    bit         job_whole;
    out_item_t  expected_plans[$];
    int         fails;

    function new();
      err_limit = RETRY_LIMIT_RST;
      whole_limit = TRACK_LIMIT_RST;
      sel_drive = '0;
      head_at = HEAD_UNKNOWN;
      cached_cyl = '0;
      cached_drive = '0;
      cached_ok = 0;
      err_cnt = '0;
      want_rst = 0;
      want_recal = 0;
      job_live = 0;
      job_drive = '0;
      job_wr = 0;
      job_cyl = '0;
      job_head = 0;
      job_sect = '0;
      job_seek = '0;
      job_slot = '0;
      job_phase = PH_IDLE;
      job_whole = 0;
      fails = 0;
    endfunction

    static function disk_geom_t geom_of(logic [2:0] ft);
      disk_geom_t g;
      case (ft)
        3'd1:    g = '{size: 12'd720,  spt: 5'd9,  stretch: 1'b0};
        3'd2:    g = '{size: 12'd2400, spt: 5'd15, stretch: 1'b0};
        3'd3:    g = '{size: 12'd720,  spt: 5'd9,  stretch: 1'b1};
        3'd4:    g = '{size: 12'd1440, spt: 5'd9,  stretch: 1'b0};
        3'd5:    g = '{size: 12'd720,  spt: 5'd9,  stretch: 1'b1};
        3'd6:    g = '{size: 12'd1440, spt: 5'd9,  stretch: 1'b0};
        3'd7:    g = '{size: 12'd2880, spt: 5'd18, stretch: 1'b0};
        default: g = '{size: 12'd0,    spt: 5'd0,  stretch: 1'b0};
      endcase
      return g;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] value);
      if (idx == CFG_RETRY_LIMIT) begin
        err_limit = value;
      end else begin
        whole_limit = value[3:0];
      end
    endfunction

    function void plan(outcome_t oc, bit geo, bit need, bit whole, logic [5:0] slot, bit cw);
      out_item_t r;
      r.outcome = oc;
      r.cylinder = geo ? job_cyl : '0;
      r.head_number = geo ? job_head : 1'b0;
      r.sector_number = geo ? job_sect : '0;
      r.seek_cylinder = geo ? job_seek : '0;
      r.need_seek = need;
      r.whole_track = whole;
      r.cache_slot = slot;
      r.cache_write = cw;
      r.want_reset = want_rst;
      r.want_recalibrate = want_recal;
      r.retries = err_cnt;
      expected_plans.push_back(r);
    endfunction

    function void start_attempt(bit retry);
      bit hit;
      bit flags;
      bit need;
      bit whole;
      hit = cached_ok && cached_cyl == job_seek && cached_drive == job_drive;
      if (hit && !job_wr) begin
        job_live = 0;
        job_phase = PH_IDLE;
        plan(OUT_CACHED, 1, 0, 0, job_slot, 0);
        return;
      end
      whole = !job_wr && (err_cnt < whole_limit);
      flags = want_rst || want_recal;
      need = flags || job_seek != head_at;
      plan(retry ? OUT_RETRY : OUT_START, 1, need, whole, hit ? job_slot : 6'd0, hit);
      // The reset and recalibrate exchanges count as done once reported.
      if (flags) begin
        want_rst = 0;
        want_recal = 0;
        head_at = HEAD_UNKNOWN;
      end
      job_whole = whole;
      job_phase = need ? PH_SEEK : PH_XFER;
      if (!need && whole) begin
        cached_ok = 0;
      end
    endfunction

    function void count_error();
      int nxt;
      bit give_up;
      nxt = int'(err_cnt) + 1;
      give_up = nxt > int'(err_limit);
      head_at = HEAD_UNKNOWN;
      err_cnt = (nxt > 31) ? 5'd31 : 5'(nxt);
      if (nxt > int'(err_limit) / 2) begin
        want_rst = 1;
      end else begin
        want_recal = 1;
      end
      if (give_up) begin
        job_live = 0;
        job_phase = PH_IDLE;
        plan(OUT_FAIL, 1, 0, 0, 6'd0, 0);
      end else begin
        start_attempt(1);
      end
    endfunction

    function void take_request(in_item_t ev);
      disk_geom_t g;
      int q;
      int h;
      int c;
      int blk;
      job_live = 0;
      job_phase = PH_IDLE;
      err_cnt = '0;
      if (int'(ev.drive) >= NUM_DRIVES) begin
        plan(OUT_FAIL, 0, 0, 0, 6'd0, 0);
        return;
      end
      if (ev.drive != sel_drive) begin
        head_at = HEAD_UNKNOWN;
      end
      sel_drive = ev.drive;
      g = geom_of((int'(ev.format_type) < NUM_FORMATS) ? ev.format_type : 3'd0);
      blk = int'(ev.block);
      if (blk + 2 > int'(g.size) || g.spt == 0) begin
        plan(OUT_FAIL, 0, 0, 0, 6'd0, 0);
        return;
      end
      q = blk / int'(g.spt);
      h = q % 2;
      c = q / 2;
      job_live = 1;
      job_drive = ev.drive;
      job_wr = ev.is_write;
      job_cyl = 7'(c);
      job_head = h[0];
      job_sect = 5'(blk % int'(g.spt) + 1);
      job_seek = 8'(c << g.stretch);
      job_slot = 6'(blk % int'(g.spt) + h * int'(g.spt));
      start_attempt(0);
    endfunction

    function void predict_event(in_item_t ev);
      case (ev.kind)
        KIND_REQUEST: take_request(ev);
        KIND_SEEK: begin
          if (!job_live || job_phase != PH_SEEK) begin
            plan(OUT_IGNORED, 0, 0, 0, 6'd0, 0);
          end else if (ev.reply_count != SEEK_REPLIES ||
                       (ev.status0 & SEEK_ST0_MASK) != SEEK_ST0_OK ||
                       ev.status1 != job_seek) begin
            want_recal = 1;
            count_error();
          end else begin
            head_at = ev.status1;
            job_phase = PH_XFER;
            if (job_whole) begin
              cached_ok = 0;
            end
            plan(OUT_START, 1, 0, job_whole, 6'd0, 0);
          end
        end
        KIND_XFER: begin
          if (!job_live || job_phase != PH_XFER) begin
            plan(OUT_IGNORED, 0, 0, 0, 6'd0, 0);
          end else if (ev.reply_count != XFER_REPLIES ||
                       (ev.status0 & XFER_ST0_MASK) != 0 ||
                       (ev.status1 & XFER_ST1_MASK) != 0 ||
                       (ev.status2 & XFER_ST2_MASK) != 0) begin
            if ((ev.status1 & ST1_NOT_WRITABLE) != 0) begin
              job_live = 0;
              job_phase = PH_IDLE;
              plan(OUT_PROTECT, 1, 0, 0, 6'd0, 0);
            end else begin
              count_error();
            end
          end else begin
            if (job_whole) begin
              cached_cyl = job_seek;
              cached_drive = job_drive;
              cached_ok = 1;
            end
            job_live = 0;
            job_phase = PH_IDLE;
            plan(OUT_DONE, 1, 0, job_whole, job_whole ? job_slot : 6'd0, 0);
          end
        end
        default: begin
          if (int'(ev.drive) < NUM_DRIVES) begin
            cached_ok = 0;
          end
          plan(OUT_IGNORED, 0, 0, 0, 6'd0, 0);
        end
      endcase
    endfunction

    function void report(string msg);
      if (fails < PRINT_CAP) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      fails++;
    endfunction

    function void compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
        report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (expected_plans.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      want = expected_plans.pop_front();
      compare_field("outcome", got.outcome, want.outcome);
      compare_field("cylinder", got.cylinder, want.cylinder);
      compare_field("head_number", got.head_number, want.head_number);
      compare_field("sector_number", got.sector_number, want.sector_number);
      compare_field("seek_cylinder", got.seek_cylinder, want.seek_cylinder);
      compare_field("need_seek", got.need_seek, want.need_seek);
      compare_field("whole_track", got.whole_track, want.whole_track);
      compare_field("cache_slot", got.cache_slot, want.cache_slot);
      compare_field("cache_write", got.cache_write, want.cache_write);
      compare_field("want_reset", got.want_reset, want.want_reset);
      compare_field("want_recalibrate", got.want_recalibrate, want.want_recalibrate);
      compare_field("retries", got.retries, want.retries);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  planner_model model = new();

  int         err_pct;
  int         noise_pct;
  bit         quiet;
  int         items_taken;
  int         hold_left;
  int         run_left;
  bit         pressure_done;
  int         stuck_cycles;
  logic [2:0]  last_fmt;
  logic [11:0] last_blk;
  logic [1:0]  last_drive;

  floppy_request_planner DUT (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      model.check_outcome(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off to back up the input, none at the end.
  always @(negedge clk) begin
    if (!pressure_done && items_taken >= PRESSURE_AT) begin
      pressure_done = 1;
      hold_left = PRESSURE_LEN;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else if (run_left > 0) begin
      out_stall = 1'b0;
      run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall = 1'b1;
      hold_left = $urandom_range(0, 17);
    end else begin
      out_stall = 1'b0;
      run_left = $urandom_range(0, 40);
    end
  end

  function automatic logic [7:0] masked_bit(logic [7:0] mask);
    int b;
    do begin
      b = $urandom_range(0, 7);
    end while (mask[b] == 1'b0);
    return 8'(1) << b;
  endfunction

  function automatic in_item_t mk_item(kind_t k, logic [1:0] drv, logic [2:0] ft,
                                       logic [11:0] blk, bit wr);
    in_item_t ev;
    ev = '0;
    ev.kind = k;
    ev.drive = drv;
    ev.format_type = ft;
    ev.block = blk;
    ev.is_write = wr;
    return ev;
  endfunction

  function automatic in_item_t mk_seek(bit ok);
    in_item_t ev;
    ev = mk_item(KIND_SEEK, 2'd0, 3'd0, 12'd0, 0);
    ev.reply_count = SEEK_REPLIES;
    ev.status0 = SEEK_ST0_OK;
    ev.status1 = ok ? model.job_seek : ~model.job_seek;
    return ev;
  endfunction

  function automatic in_item_t mk_xfer(logic [2:0] nrep, logic [7:0] st1);
    in_item_t ev;
    ev = mk_item(KIND_XFER, 2'd0, 3'd0, 12'd0, 0);
    ev.reply_count = nrep;
    ev.status1 = st1;
    return ev;
  endfunction

  function automatic in_item_t gen_event();
    in_item_t   ev;
    logic [63:0] raw;
    disk_geom_t g;
    int         pick;
    int         span;
    int         blk;
    raw = {$urandom, $urandom};
    ev = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < noise_pct) begin
      return ev;
    end
    if (model.job_phase == PH_SEEK && pick < 92) begin
      ev.kind = KIND_SEEK;
      ev.reply_count = SEEK_REPLIES;
      ev.status0 = SEEK_ST0_OK | 8'($urandom_range(0, 7));
      ev.status1 = model.job_seek;
      if ($urandom_range(0, 99) < err_pct) begin
        case ($urandom_range(0, 2))
          0: ev.reply_count = 3'(($urandom_range(0, 6) + 3) % 8);
          1: ev.status0 = ev.status0 ^ masked_bit(SEEK_ST0_MASK);
          default: ev.status1 = ev.status1 ^ masked_bit(8'hFF);
        endcase
      end
    end else if (model.job_phase == PH_XFER && pick < 92) begin
      ev.kind = KIND_XFER;
      ev.reply_count = XFER_REPLIES;
      ev.status0 = ev.status0 & ~XFER_ST0_MASK;
      ev.status1 = ev.status1 & ~XFER_ST1_MASK;
      ev.status2 = ev.status2 & ~XFER_ST2_MASK;
      if ($urandom_range(0, 99) < err_pct) begin
        case ($urandom_range(0, 4))
          0: ev.reply_count = 3'($urandom_range(0, 6));
          1: ev.status0 = ev.status0 | masked_bit(XFER_ST0_MASK);
          2: ev.status1 = ev.status1 | masked_bit(XFER_ST1_MASK & ~ST1_NOT_WRITABLE);
          3: ev.status2 = ev.status2 | masked_bit(XFER_ST2_MASK);
          default: ev.status1 = ev.status1 | ST1_NOT_WRITABLE;
        endcase
      end
    end else if (model.job_phase == PH_IDLE && pick >= 94) begin
      ev.kind = KIND_CHANGE;
    end else begin
      ev.kind = KIND_REQUEST;
      ev.is_write = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 7) begin
        ev.drive = last_drive;
        ev.format_type = last_fmt;
      end else if ($urandom_range(0, 1) == 0) begin
        ev.drive = 2'($urandom_range(0, 1));
      end
      g = planner_model::geom_of(ev.format_type);
      pick = $urandom_range(0, 99);
      if (g.size >= 2 && pick >= 8) begin
        span = 2 * int'(g.spt);
        if (pick < 16) begin
          blk = int'(g.size) - 1 - $urandom_range(0, 1);
        end else if (pick < 55) begin
          // Stay on the last cylinder so that the track cache gets hits.
          blk = int'(last_blk) - int'(last_blk) % span + $urandom_range(0, span - 1);
          if (blk + 2 > int'(g.size)) begin
            blk = int'(g.size) - 2;
          end
        end else begin
          blk = $urandom_range(0, int'(g.size) - 2);
        end
        ev.block = 12'(blk);
      end
      last_drive = ev.drive;
      last_fmt = (ev.format_type == 3'd0) ? 3'($urandom_range(1, 7)) : ev.format_type;
      last_blk = ev.block;
    end
    return ev;
  endfunction

  task automatic send_item(input in_item_t ev);
    @(negedge clk);
    in_valid = 1'b1;
    in_item = ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.predict_event(ev);
    items_taken++;
  endtask

  task automatic pause();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
  endtask

  task automatic push(input in_item_t ev);
    send_item(ev);
    pause();
  endtask

  task automatic set_regs(input logic [4:0] max_err, input logic [3:0] lim);
    @(negedge clk);
    in_valid = 1'b0;
    while (model.expected_plans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_RETRY_LIMIT;
    cfg_data = max_err;
    @(negedge clk);
    cfg_index = CFG_TRACK_LIMIT;
    cfg_data = CFG_DATA_W'(lim);
    @(negedge clk);
    cfg_we = 1'b0;
    model.set_reg(CFG_RETRY_LIMIT, max_err);
    model.set_reg(CFG_TRACK_LIMIT, 5'(lim));
  endtask

  task automatic run_phase(input logic [4:0] max_err, input logic [3:0] lim,
                           input int errp, input int noisep, input int count,
                           input bit quiet_tail);
    set_regs(max_err, lim);
    err_pct = errp;
    noise_pct = noisep;
    for (int i = 0; i < count; i++) begin
      if (quiet_tail && i >= count / 2) begin
        quiet = 1;
      end
      send_item(gen_event());
      pause();
    end
  endtask

  task automatic run_directed();
    // Events that nothing awaits, and the all-ones and all-zero items.
    push(mk_seek(1));
    push(mk_xfer(XFER_REPLIES, 8'h00));
    push(in_item_t'('1));
    push(mk_item(KIND_REQUEST, 2'd0, 3'd0, 12'd0, 0));
    // Last legal block, one past it, and the top of the block field.
    push(mk_item(KIND_REQUEST, 2'd0, 3'd1, 12'd718, 0));
    push(mk_item(KIND_REQUEST, 2'd0, 3'd1, 12'd719, 0));
    push(mk_item(KIND_REQUEST, 2'd1, 3'd7, 12'd4095, 0));
    // Whole-track read fills the cache, then a read and a write hit it.
    push(mk_item(KIND_REQUEST, 2'd1, 3'd7, 12'd2878, 0));
    push(mk_seek(1));
    push(mk_xfer(XFER_REPLIES, 8'h00));
    push(mk_item(KIND_REQUEST, 2'd1, 3'd7, 12'd2870, 0));
    push(mk_item(KIND_REQUEST, 2'd1, 3'd7, 12'd2870, 1));
    push(mk_xfer(XFER_REPLIES, ST1_NOT_WRITABLE));
    // Stretched format, block one past its last, then seeks and transfers that nothing awaits.
    push(mk_item(KIND_REQUEST, 2'd2, 3'd3, 12'd719, 1));
    push(mk_seek(0));
    push(mk_seek(1));
    push(mk_xfer(3'd3, 8'h00));
    push(mk_seek(1));
    push(mk_xfer(XFER_REPLIES, 8'h00));
    // A disk change drops the cache no matter which drive holds it.
    push(mk_item(KIND_CHANGE, 2'd0, 3'd0, 12'd0, 0));
    push(mk_item(KIND_REQUEST, 2'd1, 3'd7, 12'd2870, 0));
    // A new request replaces the pending one.
    push(mk_item(KIND_REQUEST, 2'd0, 3'd2, 12'd0, 0));
    push(mk_item(KIND_SEEK, 2'd0, 3'd0, 12'd0, 0));
    push(mk_item(KIND_REQUEST, 2'd3, 3'd5, 12'd0, 1));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RETRY_LIMIT;
    cfg_data = '0;
    err_pct = 15;
    noise_pct = 5;
    quiet = 0;
    items_taken = 0;
    hold_left = 0;
    run_left = 0;
    pressure_done = 0;
    stuck_cycles = 0;
    last_fmt = 3'd1;
    last_blk = '0;
    last_drive = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_phase(5'd0, 4'd15, 20, 5, 250, 0);
    run_phase(5'd31, 4'd0, 98, 1, 150, 0);
    run_phase(5'd5, 4'd2, 25, 5, 450, 0);
    run_phase(5'd12, 4'd4, 10, 5, 850, 1);

    @(negedge clk);
    in_valid = 1'b0;
    while (model.expected_plans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.fails == 0 && model.expected_plans.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== floppy_request_planner.f =====
rtl/core/frp_pkg.sv
rtl/core/frp_ctrl.sv
rtl/core/frp_datapath.sv
rtl/core/floppy_request_planner.sv
rtl/core/frp_checker.sv
tb/floppy_request_planner_tb.sv
